>>> rtl/pcb_pkg.sv
// pcb_pkg: shared types, register codes and the float to fixed conversion
// for the point crop box filter
// no dependencies
`default_nettype none

package pcb_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned COORD_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X  = 3'd0,
    REG_BOX_Y  = 3'd1,
    REG_BOX_Z  = 3'd2,
    REG_ROW_X  = 3'd3,
    REG_ROW_Y  = 3'd4,
    REG_ROW_Z  = 3'd5,
    REG_MODE   = 3'd6,
    REG_UNUSED = 3'd7
  } cfg_reg_t;

  localparam int unsigned MODE_XFORM = 0;
  localparam int unsigned MODE_OUTSIDE = 1;

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic [2:0][COORD_W-1:0] vec3_t;
  typedef logic [2:0][CFG_DATA_W-1:0] cfg3_t;

  // per-point side information carried down the pipeline
  typedef struct packed {
    logic [COORD_W-1:0] x_bits;
    logic [COORD_W-1:0] y_bits;
    logic [COORD_W-1:0] z_bits;
    logic               last;
    logic               nf;
  } meta_t;

  // ieee single to signed q16.16, truncating, saturating
  function automatic logic signed [COORD_W-1:0] to_q16(input logic [COORD_W-1:0] bits);
    logic [7:0]  e;
    logic [23:0] man;
    logic [30:0] mag;
    logic [7:0]  sh;
    logic [7:0]  rsh;
    logic signed [COORD_W-1:0] res;
    e   = bits[30:23];
    man = {1'b1, bits[22:0]};
    sh  = e - 8'd134;
    rsh = 8'd134 - e;
    mag = '0;
    if (e == 8'd0) begin
      mag = '0;
    end else if (e >= 8'd142) begin
      mag = '0;
    end else if (e >= 8'd134) begin
      mag = 31'(man) << sh[2:0];
    end else if (rsh >= 8'd24) begin
      mag = '0;
    end else begin
      mag = 31'(man >> rsh[4:0]);
    end
    if (e >= 8'd142) begin
      res = bits[31] ? Q_MIN : Q_MAX;
    end else begin
      res = bits[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pcb_convert.sv
// pcb_convert: first pipeline stage, non-finite check and float to q16.16
// depends on pcb_pkg
`default_nettype none

module pcb_convert #(
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire pcb_pkg::meta_t           in_meta,
  input  wire logic [PAYLOAD_WIDTH-1:0] in_payload,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output pcb_pkg::meta_t                out_meta,
  output logic [PAYLOAD_WIDTH-1:0]      out_payload,
  output pcb_pkg::vec3_t                out_coord
);

  logic                     valid_r;
  pcb_pkg::meta_t           meta_r;
  pcb_pkg::meta_t           meta_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  pcb_pkg::vec3_t           coord_r;
  pcb_pkg::vec3_t           coord_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    meta_nxt    = in_meta;
    meta_nxt.nf = (&in_meta.x_bits[30:23]) || (&in_meta.y_bits[30:23]) ||
                  (&in_meta.z_bits[30:23]);
    coord_nxt[0] = pcb_pkg::to_q16(in_meta.x_bits);
    coord_nxt[1] = pcb_pkg::to_q16(in_meta.y_bits);
    coord_nxt[2] = pcb_pkg::to_q16(in_meta.z_bits);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meta_r  <= meta_nxt;
      pay_r   <= in_payload;
      coord_r <= coord_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_meta    = meta_r;
  assign out_payload = pay_r;
  assign out_coord   = coord_r;

endmodule

`default_nettype wire

>>> rtl/pcb_xform.sv
// pcb_xform: three pipeline stages for the affine transform
// (multiply, sum, shift with translation and saturation)
// depends on pcb_pkg
`default_nettype none

module pcb_xform #(
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pcb_pkg::cfg3_t           rows,
  input  wire logic                     xform_en,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire pcb_pkg::meta_t           in_meta,
  input  wire logic [PAYLOAD_WIDTH-1:0] in_payload,
  input  wire pcb_pkg::vec3_t           in_coord,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output pcb_pkg::meta_t                out_meta,
  output logic [PAYLOAD_WIDTH-1:0]      out_payload,
  output pcb_pkg::vec3_t                out_coord
);

  logic [2:0]               valid_r;
  logic [2:0]               rdy;
  pcb_pkg::meta_t           meta_r [3];
  logic [PAYLOAD_WIDTH-1:0] pay_r  [3];
  pcb_pkg::vec3_t           raw_r  [2];
  logic signed [47:0]       prod_r [3][3];
  logic signed [47:0]       prod_nxt [3][3];
  logic signed [49:0]       acc_r  [3];
  logic signed [49:0]       acc_nxt [3];
  pcb_pkg::vec3_t           coord_r;
  pcb_pkg::vec3_t           coord_nxt;
  logic signed [35:0]       shifted [3];
  logic signed [36:0]       total [3];

  assign rdy[2]   = !valid_r[2] || out_ready;
  assign rdy[1]   = !valid_r[1] || rdy[2];
  assign rdy[0]   = !valid_r[0] || rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = 48'($signed(rows[r][16*c +: 16])) * 48'($signed(in_coord[c]));
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = 50'(prod_r[r][0]) + 50'(prod_r[r][1]) + 50'(prod_r[r][2]);
    end
  end

  // floor shift by 14, add translation in q8.8, saturate to 32 bits; raw input if xform_en is low
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r] = acc_r[r][49:14];
      total[r]   = 37'(shifted[r]) + 37'($signed({rows[r][63:48], 8'd0}));
      if (total[r][36:31] != {6{total[r][36]}}) begin
        coord_nxt[r] = total[r][36] ? pcb_pkg::Q_MIN : pcb_pkg::Q_MAX;
      end else begin
        coord_nxt[r] = total[r][31:0];
      end
      if (!xform_en) begin
        coord_nxt[r] = raw_r[1][r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) begin
        valid_r[0] <= in_valid;
      end
      if (rdy[1]) begin
        valid_r[1] <= valid_r[0];
      end
      if (rdy[2]) begin
        valid_r[2] <= valid_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy[0]) begin
      meta_r[0] <= in_meta;
      pay_r[0]  <= in_payload;
      raw_r[0]  <= in_coord;
      prod_r    <= prod_nxt;
    end
    if (valid_r[0] && rdy[1]) begin
      meta_r[1] <= meta_r[0];
      pay_r[1]  <= pay_r[0];
      raw_r[1]  <= raw_r[0];
      acc_r     <= acc_nxt;
    end
    if (valid_r[1] && rdy[2]) begin
      meta_r[2] <= meta_r[1];
      pay_r[2]  <= pay_r[1];
      coord_r   <= coord_nxt;
    end
  end

  assign out_valid   = valid_r[2];
  assign out_meta    = meta_r[2];
  assign out_payload = pay_r[2];
  assign out_coord   = coord_r;

endmodule

`default_nettype wire

>>> rtl/pcb_crop.sv
// pcb_crop: last pipeline stage, box test, per-cloud counters and the
// output register
// depends on pcb_pkg
`default_nettype none

module pcb_crop #(
  parameter int unsigned PAYLOAD_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pcb_pkg::cfg3_t           box,
  input  wire logic                     outside_sel,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire pcb_pkg::meta_t           in_meta,
  input  wire logic [PAYLOAD_WIDTH-1:0] in_payload,
  input  wire pcb_pkg::vec3_t           in_coord,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output pcb_pkg::meta_t                out_meta,
  output logic [PAYLOAD_WIDTH-1:0]      out_payload,
  output logic                          out_keep,
  output logic [COUNT_WIDTH-1:0]        out_kept_total,
  output logic [COUNT_WIDTH-1:0]        out_nf_total
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                     valid_r;
  pcb_pkg::meta_t           meta_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic                     keep_r;
  logic                     keep_nxt;
  logic [COUNT_WIDTH-1:0]   kept_tot_r;
  logic [COUNT_WIDTH-1:0]   nf_tot_r;
  logic [COUNT_WIDTH-1:0]   kept_cnt_r;
  logic [COUNT_WIDTH-1:0]   kept_cnt_nxt;
  logic [COUNT_WIDTH-1:0]   nf_cnt_r;
  logic [COUNT_WIDTH-1:0]   nf_cnt_nxt;
  logic [2:0]               inside_ax;
  logic                     load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      inside_ax[a] = ($signed(in_coord[a]) > $signed(box[a][31:0])) &&
                     ($signed(in_coord[a]) < $signed(box[a][63:32]));
    end
    keep_nxt     = !in_meta.nf && ((&inside_ax) != outside_sel);
    kept_cnt_nxt = kept_cnt_r;
    if (keep_nxt && kept_cnt_r != CNT_MAX) begin
      kept_cnt_nxt = kept_cnt_r + 1'b1;
    end
    nf_cnt_nxt = nf_cnt_r;
    if (in_meta.nf && nf_cnt_r != CNT_MAX) begin
      nf_cnt_nxt = nf_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      kept_cnt_r <= '0;
      nf_cnt_r   <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (load) begin
        kept_cnt_r <= in_meta.last ? '0 : kept_cnt_nxt;
        nf_cnt_r   <= in_meta.last ? '0 : nf_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_r     <= in_meta;
      pay_r      <= in_payload;
      keep_r     <= keep_nxt;
      kept_tot_r <= kept_cnt_nxt;
      nf_tot_r   <= nf_cnt_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_meta       = meta_r;
  assign out_payload    = pay_r;
  assign out_keep       = keep_r;
  assign out_kept_total = kept_tot_r;
  assign out_nf_total   = nf_tot_r;

  a_keep_not_nf : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !(keep_r && meta_r.nf))
    else $error("non-finite point marked as kept");

  a_cloud_clear : assert property (@(posedge clk) disable iff (!rst_n)
    load && in_meta.last |=> kept_cnt_r == '0 && nf_cnt_r == '0)
    else $error("counters not cleared after end of cloud");

  a_kept_step : assert property (@(posedge clk) disable iff (!rst_n)
    load && !in_meta.last && keep_nxt && kept_cnt_r != CNT_MAX
      |=> kept_cnt_r == $past(kept_cnt_r) + 1'b1)
    else $error("kept counter missed a kept point");

  a_total_matches : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> kept_tot_r == $past(kept_cnt_nxt) && nf_tot_r == $past(nf_cnt_nxt))
    else $error("reported totals differ from counter update");

endmodule

`default_nettype wire

>>> rtl/point_crop_box_filter_top.sv
// point_crop_box_filter_top: crop-box filter for a stream of 3d points,
// configuration registers and stream packing
// depends on pcb_pkg, pcb_convert, pcb_xform, pcb_crop
`default_nettype none

// Takes one point per clock while the output is not stalled and returns one
// result per point, in order. The pipeline has five register stages: float
// to q16.16 conversion, the nine coefficient multiplies, the row sums,
// shift/translate/saturate, and the box test with the per-cloud counters;
// the 16 x 32 multiply stage sets the clock. Every stage has its own valid
// bit and takes a new point whenever it is empty or its successor moves, so
// a stall at out_tready holds data without loss or repetition. Configuration
// writes are always accepted and must only be made while no point is in
// flight.
module point_crop_box_filter_top #(
  parameter int unsigned PAYLOAD_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH   = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pcb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // x_bits, y_bits, z_bits, payload, zero fill
  input  wire logic [((96+PAYLOAD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_x_bits, out_y_bits, out_z_bits, out_payload, kept_total,
  // non_finite_total, zero fill
  output logic [((96+PAYLOAD_WIDTH+2*COUNT_WIDTH+7)/8)*8-1:0] out_tdata,
  // keep, non_finite
  output logic [1:0]                              out_tuser,
  output logic                                    out_tlast
);

  localparam int unsigned OUT_W = ((96 + PAYLOAD_WIDTH + 2*COUNT_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_USED = 96 + PAYLOAD_WIDTH + 2*COUNT_WIDTH;

  pcb_pkg::cfg3_t box_r;
  pcb_pkg::cfg3_t row_r;
  logic [1:0]     mode_r;

  pcb_pkg::meta_t           in_meta;
  logic                     cv_valid, cv_ready;
  pcb_pkg::meta_t           cv_meta;
  logic [PAYLOAD_WIDTH-1:0] cv_pay;
  pcb_pkg::vec3_t           cv_coord;
  logic                     xf_valid, xf_ready;
  pcb_pkg::meta_t           xf_meta;
  logic [PAYLOAD_WIDTH-1:0] xf_pay;
  pcb_pkg::vec3_t           xf_coord;
  pcb_pkg::meta_t           cr_meta;
  logic [PAYLOAD_WIDTH-1:0] cr_pay;
  logic                     cr_keep;
  logic [COUNT_WIDTH-1:0]   cr_kept;
  logic [COUNT_WIDTH-1:0]   cr_nf;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r  <= '0;
      row_r  <= '0;
      mode_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pcb_pkg::cfg_reg_t'(cfg_index))
        pcb_pkg::REG_BOX_X: box_r[0] <= cfg_data;
        pcb_pkg::REG_BOX_Y: box_r[1] <= cfg_data;
        pcb_pkg::REG_BOX_Z: box_r[2] <= cfg_data;
        pcb_pkg::REG_ROW_X: row_r[0] <= cfg_data;
        pcb_pkg::REG_ROW_Y: row_r[1] <= cfg_data;
        pcb_pkg::REG_ROW_Z: row_r[2] <= cfg_data;
        pcb_pkg::REG_MODE:  mode_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_meta.x_bits = in_tdata[31:0];
    in_meta.y_bits = in_tdata[63:32];
    in_meta.z_bits = in_tdata[95:64];
    in_meta.last   = in_tlast;
    in_meta.nf     = 1'b0;
  end

  pcb_convert #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_convert (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_meta     (in_meta),
    .in_payload  (in_tdata[96 +: PAYLOAD_WIDTH]),
    .out_valid   (cv_valid),
    .out_ready   (cv_ready),
    .out_meta    (cv_meta),
    .out_payload (cv_pay),
    .out_coord   (cv_coord)
  );

  pcb_xform #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_xform (
    .clk         (clk),
    .rst_n       (rst_n),
    .rows        (row_r),
    .xform_en    (mode_r[pcb_pkg::MODE_XFORM]),
    .in_valid    (cv_valid),
    .in_ready    (cv_ready),
    .in_meta     (cv_meta),
    .in_payload  (cv_pay),
    .in_coord    (cv_coord),
    .out_valid   (xf_valid),
    .out_ready   (xf_ready),
    .out_meta    (xf_meta),
    .out_payload (xf_pay),
    .out_coord   (xf_coord)
  );

  pcb_crop #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_crop (
    .clk            (clk),
    .rst_n          (rst_n),
    .box            (box_r),
    .outside_sel    (mode_r[pcb_pkg::MODE_OUTSIDE]),
    .in_valid       (xf_valid),
    .in_ready       (xf_ready),
    .in_meta        (xf_meta),
    .in_payload     (xf_pay),
    .in_coord       (xf_coord),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_meta       (cr_meta),
    .out_payload    (cr_pay),
    .out_keep       (cr_keep),
    .out_kept_total (cr_kept),
    .out_nf_total   (cr_nf)
  );

  assign out_tdata = OUT_W'({cr_nf, cr_kept, cr_pay,
                             cr_meta.z_bits, cr_meta.y_bits, cr_meta.x_bits});
  assign out_tuser = {cr_meta.nf, cr_keep};
  assign out_tlast = cr_meta.last;

  a_out_pad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >> OUT_USED) == '0)
    else $error("output fill bits not zero");

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking testbench for point_crop_box_filter_top, with streaming stimulus,
// a bit-exact crop-box predictor and an in-order result scoreboard
// depends on pcb_pkg and point_crop_box_filter_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PL_W = 64;
  localparam int CNT_W = 32;
  localparam int IN_W = ((96 + PL_W + 7) / 8) * 8;
  localparam int OUT_W = ((96 + PL_W + 2 * CNT_W + 7) / 8) * 8;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
  localparam int N_PHASES = 12;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    logic [31:0]     xb;
    logic [31:0]     yb;
    logic [31:0]     zb;
    logic [PL_W-1:0] pl;
    logic            last;
  } point_t;

  typedef struct packed {
    logic             keep;
    logic             nf;
    logic [31:0]      xb;
    logic [31:0]      yb;
    logic [31:0]      zb;
    logic [PL_W-1:0]  pl;
    logic             cloud_end;
    logic [CNT_W-1:0] kept_tot;
    logic [CNT_W-1:0] nf_tot;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pcb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  point_t points_queued[$];
  verdict_t verdicts_due[$];
  point_t on_bus;
  logic in_fire = 1'b0;
  bit calm = 1'b0;
  bit hold_start = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int err_count = 0;

  // register shadow and per-cloud counters of the predictor
  logic [63:0] box_reg[3] = '{64'd0, 64'd0, 64'd0};
  logic [63:0] row_reg[3] = '{64'd0, 64'd0, 64'd0};
  logic [1:0] mode_reg = 2'd0;
  longint unsigned kept_run = 0;
  longint unsigned nf_run = 0;
  bit box_halves[3] = '{1'b0, 1'b0, 1'b0};
  int box_lo_h[3];
  int box_hi_h[3];

  point_crop_box_filter_top #(
    .PAYLOAD_WIDTH(PL_W),
    .COUNT_WIDTH  (CNT_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic longint float_to_q16(logic [31:0] b);
    int unsigned e;
    longint unsigned man;
    longint unsigned mag;
    e = b[30:23];
    man = {40'd0, 1'b1, b[22:0]};
    if (e == 0) begin
      mag = 0;
    end else if (e >= 142) begin
      mag = 64'h1_0000_0000;
    end else if (e >= 134) begin
      mag = man << (e - 134);
    end else if (134 - e >= 32) begin
      mag = 0;
    end else begin
      mag = man >> (134 - e);
    end
    if (!b[31]) begin
      return (mag > 64'h7fff_ffff) ? 64'sh7fff_ffff : longint'(mag);
    end
    if (mag >= 64'h8000_0000) begin
      return -64'sh8000_0000;
    end
    return -longint'(mag);
  endfunction

  function automatic longint row_eval(logic [63:0] row, longint a, longint b, longint c);
    longint acc;
    acc = longint'($signed(row[15:0])) * a + longint'($signed(row[31:16])) * b +
          longint'($signed(row[47:32])) * c;
    acc = (acc >>> 14) + longint'($signed(row[63:48])) * 256;
    if (acc > 64'sh7fff_ffff) begin
      return 64'sh7fff_ffff;
    end
    if (acc < -64'sh8000_0000) begin
      return -64'sh8000_0000;
    end
    return acc;
  endfunction

  function automatic bit in_span(logic [63:0] box, longint v);
    return v > longint'($signed(box[31:0])) && v < longint'($signed(box[63:32]));
  endfunction

  function automatic verdict_t crop_verdict(point_t p);
    verdict_t v;
    longint cx, cy, cz, tx, ty, tz;
    bit in_box;
    v = '0;
    v.xb = p.xb;
    v.yb = p.yb;
    v.zb = p.zb;
    v.pl = p.pl;
    v.cloud_end = p.last;
    if (p.xb[30:23] == 8'hff || p.yb[30:23] == 8'hff || p.zb[30:23] == 8'hff) begin
      v.nf = 1'b1;
      if (nf_run < CNT_MAX) nf_run++;
    end else begin
      cx = float_to_q16(p.xb);
      cy = float_to_q16(p.yb);
      cz = float_to_q16(p.zb);
      if (mode_reg[pcb_pkg::MODE_XFORM]) begin
        tx = row_eval(row_reg[0], cx, cy, cz);
        ty = row_eval(row_reg[1], cx, cy, cz);
        tz = row_eval(row_reg[2], cx, cy, cz);
        cx = tx;
        cy = ty;
        cz = tz;
      end
      in_box = in_span(box_reg[0], cx) && in_span(box_reg[1], cy) &&
               in_span(box_reg[2], cz);
      v.keep = in_box ^ mode_reg[pcb_pkg::MODE_OUTSIDE];
      if (v.keep && kept_run < CNT_MAX) kept_run++;
    end
    v.kept_tot = kept_run[CNT_W-1:0];
    v.nf_tot = nf_run[CNT_W-1:0];
    if (p.last) begin
      kept_run = 0;
      nf_run = 0;
    end
    return v;
  endfunction

  // signed multiple of 0.5 as ieee single, magnitude below 4096 half units
  function automatic logic [31:0] halves_to_float(int h);
    int unsigned m;
    int p;
    logic [31:0] f;
    m = (h < 0) ? -h : h;
    if (m == 0) return {h < 0, 31'd0};
    p = 11;
    while (!m[p]) p--;
    f = m << (23 - p);
    return {h < 0, 8'(126 + p), f[22:0]};
  endfunction

  task automatic report(string msg);
    if (err_count < 100) $display("%0t ns mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [63:0] g, logic [63:0] w);
    if (g !== w) report($sformatf("%s got %0h expected %0h", name, g, w));
  endtask

  // input driver
  always @(negedge clk) begin
    if (in_tvalid && !in_fire) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (points_queued.size() > 0) begin
      on_bus = points_queued.pop_front();
      in_tdata <= IN_W'({on_bus.pl, on_bus.zb, on_bus.yb, on_bus.xb});
      in_tlast <= on_bus.last;
      in_tvalid <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 16);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // output backpressure
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    verdict_t want, got;
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      verdicts_due.insert(verdicts_due.size(), crop_verdict(on_bus));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.keep = out_tuser[0];
      got.nf = out_tuser[1];
      got.xb = out_tdata[31:0];
      got.yb = out_tdata[63:32];
      got.zb = out_tdata[95:64];
      got.pl = out_tdata[96 +: PL_W];
      got.kept_tot = out_tdata[96 + PL_W +: CNT_W];
      got.nf_tot = out_tdata[96 + PL_W + CNT_W +: CNT_W];
      got.cloud_end = out_tlast;
      if (verdicts_due.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        want = verdicts_due.pop_front();
        check_field("keep", got.keep, want.keep);
        check_field("non_finite", got.nf, want.nf);
        check_field("out_x_bits", got.xb, want.xb);
        check_field("out_y_bits", got.yb, want.yb);
        check_field("out_z_bits", got.zb, want.zb);
        check_field("out_payload", got.pl, want.pl);
        check_field("cloud_end", got.cloud_end, want.cloud_end);
        check_field("kept_total", got.kept_tot, want.kept_tot);
        check_field("non_finite_total", got.nf_tot, want.nf_tot);
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (points_queued.size() != 0 || in_tvalid || verdicts_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(pcb_pkg::cfg_reg_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      pcb_pkg::REG_BOX_X: box_reg[0] = v;
      pcb_pkg::REG_BOX_Y: box_reg[1] = v;
      pcb_pkg::REG_BOX_Z: box_reg[2] = v;
      pcb_pkg::REG_ROW_X: row_reg[0] = v;
      pcb_pkg::REG_ROW_Y: row_reg[1] = v;
      pcb_pkg::REG_ROW_Z: row_reg[2] = v;
      pcb_pkg::REG_MODE: mode_reg = v[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [63:0] pl, logic last);
    point_t p;
    p.xb = x;
    p.yb = y;
    p.zb = z;
    p.pl = pl[PL_W-1:0];
    p.last = last;
    points_queued.insert(points_queued.size(), p);
  endtask

  task automatic configure_random();
    pcb_pkg::cfg_reg_t box_idx[3];
    pcb_pkg::cfg_reg_t row_idx[3];
    logic [63:0] v;
    logic [15:0] c[3];
    longint lo, hi;
    box_idx = '{pcb_pkg::REG_BOX_X, pcb_pkg::REG_BOX_Y, pcb_pkg::REG_BOX_Z};
    row_idx = '{pcb_pkg::REG_ROW_X, pcb_pkg::REG_ROW_Y, pcb_pkg::REG_ROW_Z};
    for (int a = 0; a < 3; a++) begin
      box_halves[a] = 1'b0;
      case ($urandom_range(0, 9))
        0: v = {32'h7fff_ffff, 32'h8000_0000};
        1: v = {32'hfff0_0000, 32'h0010_0000};
        2: v = {$urandom, $urandom};
        3: v = 64'd0;
        default: begin
          box_lo_h[a] = -int'($urandom_range(0, 1200));
          box_hi_h[a] = $urandom_range(0, 1200);
          lo = longint'(box_lo_h[a]) * 32768;
          hi = longint'(box_hi_h[a]) * 32768;
          v = {hi[31:0], lo[31:0]};
          box_halves[a] = 1'b1;
        end
      endcase
      write_reg(box_idx[a], v);
    end
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 9))
        6: v = {$urandom, $urandom};
        7: v = 64'h7fff_7fff_7fff_7fff;
        8: v = 64'h8000_8000_8000_8000;
        9: v = 64'd0;
        default: begin
          for (int k = 0; k < 3; k++) begin
            c[k] = 16'($urandom_range(0, 16'h0fff)) - 16'h0800;
          end
          c[a] = c[a] + 16'h4000;
          v = {16'($urandom), c[2], c[1], c[0]};
        end
      endcase
      write_reg(row_idx[a], v);
    end
    write_reg(pcb_pkg::REG_MODE, 64'($urandom_range(0, 3)));
  endtask

  function automatic logic [31:0] random_coord(int axis);
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) return {1'($urandom), 8'hff, ($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom)};
    if (k < 8) return $urandom;
    if (k < 11) return {1'($urandom), 8'h00, 23'($urandom)};
    if (k < 14) return {1'($urandom), 8'($urandom_range(137, 160)), 23'($urandom)};
    if (k < 20 && box_halves[axis]) begin
      return halves_to_float($urandom_range(0, 1) ? box_lo_h[axis] : box_hi_h[axis]);
    end
    if (k < 40) return halves_to_float(int'($urandom_range(0, 1300)) - 650);
    return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
  endfunction

  initial begin
    int cloud_left;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // box of +-10 in every axis, no transform, keep inside
    write_reg(pcb_pkg::REG_BOX_X, 64'h000a_0000_fff6_0000);
    write_reg(pcb_pkg::REG_BOX_Y, 64'h000a_0000_fff6_0000);
    write_reg(pcb_pkg::REG_BOX_Z, 64'h000a_0000_fff6_0000);
    write_reg(pcb_pkg::REG_MODE, 64'd0);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 64'd0, 1'b0);
    add_point(32'h8000_0000, 32'h0000_0001, 32'h807f_ffff, '1, 1'b0);
    add_point(32'h40a0_0000, 32'hc0a0_0000, 32'h3780_0000, {$urandom, $urandom}, 1'b0);
    add_point(32'h4120_0000, 32'h0000_0000, 32'h0000_0000, 64'd0, 1'b0);
    add_point(32'h0000_0000, 32'hc120_0000, 32'h0000_0000, '1, 1'b1);
    add_point(32'h7149_f2ca, 32'h0000_0000, 32'h0000_0000, 64'd0, 1'b0);
    add_point(32'h0000_0000, 32'h0000_0000, 32'hf149_f2ca, '1, 1'b0);
    add_point(32'h46ff_ffff, 32'h4700_0000, 32'hc700_0000, 64'd0, 1'b0);
    add_point(32'h7f80_0000, 32'h0000_0000, 32'h0000_0000, '1, 1'b0);
    add_point(32'h0000_0000, 32'h7fc0_0000, 32'h0000_0000, 64'd0, 1'b0);
    add_point(32'h0000_0000, 32'h0000_0000, 32'hff80_0000, '1, 1'b0);
    add_point(32'hffff_ffff, 32'h7f80_0001, 32'h3700_0000, {$urandom, $urandom}, 1'b1);
    wait_idle();

    // transform with extreme coefficients, keep outside
    write_reg(pcb_pkg::REG_ROW_X, 64'h7fff_7fff_7fff_7fff);
    write_reg(pcb_pkg::REG_ROW_Y, 64'h8000_8000_8000_8000);
    write_reg(pcb_pkg::REG_ROW_Z, 64'h0000_4000_0000_0000);
    write_reg(pcb_pkg::REG_MODE, 64'd3);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 64'd0, 1'b0);
    add_point(32'h7149_f2ca, 32'h7149_f2ca, 32'h7149_f2ca, '1, 1'b0);
    add_point(32'hf149_f2ca, 32'hf149_f2ca, 32'hf149_f2ca, 64'd0, 1'b0);
    add_point(32'h40a0_0000, 32'h40a0_0000, 32'h40a0_0000, '1, 1'b0);
    add_point(32'h7fc0_0000, 32'h40a0_0000, 32'h0000_0000, 64'd0, 1'b0);
    add_point(32'h46ff_ffff, 32'hc700_0000, 32'h40a0_0000, '1, 1'b0);
    add_point(32'h3f80_0000, 32'hbf80_0000, 32'h3f00_0000, {$urandom, $urandom}, 1'b1);
    wait_idle();

    // inverted and full-range boxes, ignored register index
    write_reg(pcb_pkg::REG_BOX_X, 64'hfff6_0000_000a_0000);
    write_reg(pcb_pkg::REG_BOX_Y, 64'h7fff_ffff_8000_0000);
    write_reg(pcb_pkg::REG_MODE, 64'd0);
    write_reg(pcb_pkg::REG_UNUSED, '1);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 64'd0, 1'b0);
    add_point(32'h40a0_0000, 32'hf149_f2ca, 32'h0000_0000, '1, 1'b0);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 64'd0, 1'b1);
    wait_idle();
    write_reg(pcb_pkg::REG_MODE, 64'd2);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '1, 1'b0);
    add_point(32'h7f80_0000, 32'h0000_0000, 32'h0000_0000, 64'd0, 1'b1);

    cloud_left = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      configure_random();
      if (ph == N_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == PHASE_ITEMS / 2) wait_idle();
        if (cloud_left == 0) begin
          cloud_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
        end
        add_point(random_coord(0), random_coord(1), random_coord(2),
                  {$urandom, $urandom}, cloud_left == 1);
        cloud_left--;
        if (ph == 2 && i == 40) hold_start = 1'b1;
      end
    end
    wait_idle();
    if (verdicts_due.size() != 0) report("results missing at end of run");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for result transactions");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> point_crop_box_filter_top.f
rtl/pcb_pkg.sv
rtl/pcb_convert.sv
rtl/pcb_xform.sv
rtl/pcb_crop.sv
rtl/point_crop_box_filter_top.sv
tb/tb.sv
